[rtl/sbcp_pkg.sv]
// ----------------------------------------------------------------------------
// Smooth Bezier control points: shared package
// Widths, fixed-point constants, channel structs, sequencer states and the
// saturation helpers used across the block.
// ----------------------------------------------------------------------------
package sbcp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_KNOTS = 64;
    localparam int KIDX_W    = $clog2(MAX_KNOTS);
    localparam int CNT_W     = $clog2(MAX_KNOTS + 1);
    localparam int NUM_W     = 32 + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(NUM_W);
    localparam int WIDE_W    = 36;
    localparam int SEG_W     = 6;

    localparam logic signed [31:0] INT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] INT_MIN = 32'sh80000000;
    localparam logic signed [31:0] ONE_Q   = 32'(64'd1 << FRAC_BITS);
    localparam logic signed [31:0] TWO_Q   = 32'(64'd2 << FRAC_BITS);
    localparam logic signed [WIDE_W-1:0] FOUR_Q  = WIDE_W'(64'd4 << FRAC_BITS);
    localparam logic signed [WIDE_W-1:0] SEVEN_Q = WIDE_W'(64'd7 << FRAC_BITS);
    localparam logic signed [WIDE_W-1:0] W_ONE   = WIDE_W'(64'd1);

    // Reciprocal of three scaled by 2^35, rounded up; exact for inputs below 2^35.
    localparam logic [33:0] THIRD_RECIP = 34'h2aaaaaaab;

    typedef struct packed {
        logic signed [31:0] knot_x;
        logic signed [31:0] knot_y;
        logic signed [31:0] knot_z;
        logic               final_knot;
    } knot_t;

    typedef struct packed {
        logic [SEG_W-1:0]   segment;
        logic signed [31:0] first_ctrl_x;
        logic signed [31:0] first_ctrl_y;
        logic signed [31:0] first_ctrl_z;
        logic signed [31:0] second_ctrl_x;
        logic signed [31:0] second_ctrl_y;
        logic signed [31:0] second_ctrl_z;
        logic               final_segment;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [KIDX_W-1:0] addr;
        logic [31:0]       x;
        logic [31:0]       y;
        logic [31:0]       z;
    } knot_wr_t;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] cnt;
    } job_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num_mag;
        logic             neg;
        logic [31:0]      den_mag;
    } div_req_t;

    typedef enum logic [4:0] {
        BK_IDLE,
        BK_PIV0,
        BK_PIV_DIV,
        BK_PIV_WAIT,
        BK_RHS_RD0,
        BK_RHS_RD1,
        BK_RHS_MUL,
        BK_RHS_WR,
        BK_BS_RD,
        BK_BS_DIV,
        BK_BS_WAIT,
        BK_OUT_RD,
        BK_OUT_EMIT,
        BK_LIN_RD0,
        BK_LIN_RD1,
        BK_LIN_ABS,
        BK_LIN_MUL,
        BK_LIN_SUM
    } back_state_t;

    function automatic logic signed [WIDE_W-1:0] sext_w(input logic signed [31:0] v);
        return {{(WIDE_W-32){v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat_w(input logic signed [WIDE_W-1:0] v);
        logic signed [31:0] r;
        if (v > sext_w(INT_MAX)) begin
            r = INT_MAX;
        end else if (v < sext_w(INT_MIN)) begin
            r = INT_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] qmul_round(input logic signed [63:0] p);
        logic signed [63:0] t;
        logic signed [31:0] r;
        t = (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (t > 64'sh000000007fffffff) begin
            r = INT_MAX;
        end else if (t < -64'sh0000000080000000) begin
            r = INT_MIN;
        end else begin
            r = t[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/sbcp_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sbcp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/sbcp_front.sv]
// ----------------------------------------------------------------------------
// Smooth Bezier control points: front end
// Accepts knots, writes them to the knot store and queues one solve job per
// finished knot set of two or more knots.
// ----------------------------------------------------------------------------
module sbcp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  sbcp_pkg::knot_t  knot,
    input  logic             job_pop,
    output sbcp_pkg::knot_wr_t knot_wr,
    output sbcp_pkg::job_t   job
);
    import sbcp_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] qcnt_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;
    logic             accept, room, push;
    logic [CNT_W-1:0] total;

    always_comb
    begin
        accept = start & ~busy;
        room   = count_reg < CNT_W'(MAX_KNOTS);
        total  = count_reg + CNT_W'(room);
        push   = accept & knot.final_knot & (total >= CNT_W'(2));

        knot_wr.we   = accept & room;
        knot_wr.addr = count_reg[KIDX_W-1:0];
        knot_wr.x    = knot.knot_x;
        knot_wr.y    = knot.knot_y;
        knot_wr.z    = knot.knot_z;

        count_next = count_reg;
        if (accept)
        begin
            count_next = knot.final_knot ? '0 : total;
        end

        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ job_pop;
        fill_next   = fill_reg + 2'(push) - 2'(job_pop);

        job.valid = fill_reg != 2'd0;
        job.cnt   = qcnt_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            qcnt_reg[wr_ptr_reg] <= total;
        end
    end

endmodule

[rtl/sbcp_div.sv]
// ----------------------------------------------------------------------------
// Smooth Bezier control points: divider
// Bit-serial restoring divider on magnitudes, one quotient bit per cycle,
// with round-to-nearest (ties away from zero) and 32-bit saturation.
// ----------------------------------------------------------------------------
module sbcp_div (
    input  logic                clk,
    input  logic                rst_n,
    input  sbcp_pkg::div_req_t  req,
    output logic                done,
    output logic signed [31:0]  quo
);
    import sbcp_pkg::*;

    logic              run_reg, run_next;
    logic              fin_reg, fin_next;
    logic              done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [NUM_W-1:0]  q_reg, q_next;
    logic [31:0]       rem_reg, rem_next;
    logic [31:0]       den_reg, den_next;
    logic              neg_reg, neg_next;
    logic              nz_reg, nz_next;
    logic signed [31:0] quo_reg, quo_next;
    logic [32:0]       rem_sh;
    logic              fits;
    logic              up;
    logic [NUM_W:0]    q_rnd;
    logic signed [31:0] res;

    always_comb
    begin
        rem_sh = {rem_reg, num_reg[NUM_W-1]};
        fits   = rem_sh >= {1'b0, den_reg};
        up     = {rem_reg, 1'b0} >= {1'b0, den_reg};
        q_rnd  = {1'b0, q_reg} + (NUM_W+1)'(up);

        if (den_reg == 32'd0)
        begin
            res = neg_reg ? INT_MIN : (nz_reg ? INT_MAX : 32'sd0);
        end
        else if (!neg_reg)
        begin
            res = (q_rnd > (NUM_W+1)'(32'h7fffffff)) ? INT_MAX : q_rnd[31:0];
        end
        else
        begin
            res = (q_rnd > (NUM_W+1)'(33'h080000000)) ? INT_MIN
                                                      : 32'((NUM_W+1)'(0) - q_rnd);
        end

        run_next  = run_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        nz_next   = nz_reg;
        quo_next  = quo_reg;

        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = DIV_CNT_W'(NUM_W - 1);
            num_next = req.num_mag;
            q_next   = '0;
            rem_next = '0;
            den_next = req.den_mag;
            neg_next = req.neg;
            nz_next  = |req.num_mag;
        end
        else if (run_reg)
        begin
            rem_next = fits ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
            q_next   = {q_reg[NUM_W-2:0], fits};
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            quo_next  = res;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        nz_reg  <= nz_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !run_reg && !fin_reg)
        else $error("divider started while busy");
    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(fin_reg))
        else $error("divider done without a rounding step");
    a_run_fin_excl: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> !fin_reg && !done_reg)
        else $error("divider phases overlap");
`endif

endmodule

[rtl/sbcp_back.sv]
// ----------------------------------------------------------------------------
// Smooth Bezier control points: back end
// Sequencer that runs the pivot pass, the per-axis forward elimination and
// back substitution (or, for a two-knot set, a direct linear solve per
// axis), and then streams one result per segment.
module sbcp_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sbcp_pkg::job_t             job,
    output logic                       job_pop,
    output logic [sbcp_pkg::KIDX_W-1:0] knot_raddr,
    input  logic [2:0][31:0]           knot_rd,
    output logic                       back_busy,
    output logic                       result_valid,
    output sbcp_pkg::result_t          result
);
    import sbcp_pkg::*;

    back_state_t        state_reg, state_next;
    logic [KIDX_W-1:0]  idx_reg, idx_next;
    logic [KIDX_W-1:0]  n_reg, n_next;
    logic [1:0]         axis_reg, axis_next;
    logic               sel_reg, sel_next;
    logic signed [31:0] piv_prev_reg, piv_prev_next;
    logic signed [31:0] r_prev_reg, r_prev_next;
    logic signed [31:0] p1_hold_reg, p1_hold_next;
    logic signed [31:0] ka_reg, ka_next;
    logic signed [31:0] kb_reg, kb_next;
    logic signed [31:0] m_reg, m_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [32:0]        lin_x_reg, lin_x_next;
    logic               lin_neg_reg, lin_neg_next;
    logic [50:0]        lin_ph_reg, lin_ph_next;
    result_t            res_reg, res_next;
    logic               res_valid_reg, res_valid_next;

    div_req_t           div_req;
    logic               div_done;
    logic signed [31:0] div_quo;

    logic               piv_we, m_we, rhs_we;
    logic signed [31:0] piv_wdata, rhs_wdata;
    logic signed [31:0] piv_rd, m_rd, rhs_rd;
    logic [2:0]         p1_we, p2_we;
    logic signed [31:0] p1_wdata, p2_wdata;
    logic [2:0][31:0]   p1_rd, p2_rd;

    logic                is_last;
    logic signed [31:0]  knot_cur;
    logic signed [31:0]  piv_val, rs_val, r_val, bs_num, p2_val;
    logic signed [WIDE_W-1:0] raw, lin_sum;
    logic [WIDE_W-1:0]   lin_mag;
    logic [49:0]         lin_pl;
    logic [66:0]         lin_full;
    logic [31:0]         lin_q;
    logic signed [31:0]  lin_val;

    function automatic div_req_t qdiv_req(input logic signed [31:0] num,
                                          input logic signed [31:0] den);
        logic [32:0] an;
        logic [32:0] ad;
        div_req_t    r;
        an = num[31] ? 33'(33'd0 - {num[31], num}) : {1'b0, num};
        ad = den[31] ? 33'(33'd0 - {den[31], den}) : {1'b0, den};
        r.start   = 1'b1;
        r.num_mag = NUM_W'(an) << FRAC_BITS;
        r.neg     = num[31] ^ den[31];
        r.den_mag = ad[31:0];
        return r;
    endfunction

    sbcp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo)
    );

    sbcp_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_piv_ram (
        .clk(clk), .we(piv_we), .waddr(idx_reg), .wdata(piv_wdata),
        .raddr(idx_reg), .rdata(piv_rd)
    );

    sbcp_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_m_ram (
        .clk(clk), .we(m_we), .waddr(idx_reg), .wdata(div_quo),
        .raddr(idx_reg), .rdata(m_rd)
    );

    sbcp_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_rhs_ram (
        .clk(clk), .we(rhs_we), .waddr(idx_reg), .wdata(rhs_wdata),
        .raddr(idx_reg), .rdata(rhs_rd)
    );

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        sbcp_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_p1_ram (
            .clk(clk), .we(p1_we[a]), .waddr(idx_reg), .wdata(p1_wdata),
            .raddr(idx_reg), .rdata(p1_rd[a])
        );
        sbcp_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_p2_ram (
            .clk(clk), .we(p2_we[a]), .waddr(idx_reg), .wdata(p2_wdata),
            .raddr(idx_reg), .rdata(p2_rd[a])
        );
    end

    always_comb
    begin
        is_last  = idx_reg == (n_reg - KIDX_W'(1));
        knot_cur = knot_rd[axis_reg];

        piv_val = sat_w((is_last ? SEVEN_Q : FOUR_Q) - sext_w(div_quo));

        if (idx_reg == '0)
        begin
            raw = sext_w(ka_reg) + (sext_w(kb_reg) <<< 1);
        end
        else if (is_last)
        begin
            raw = (sext_w(ka_reg) <<< 3) + sext_w(kb_reg);
        end
        else
        begin
            raw = (sext_w(ka_reg) <<< 2) + (sext_w(kb_reg) <<< 1);
        end
        rs_val = sat_w(raw);
        r_val  = (idx_reg == '0) ? rs_val
                                 : sat_w(sext_w(rs_val) - sext_w(qmul_round(prod_reg)));

        bs_num = is_last ? rhs_rd : sat_w(sext_w(rhs_rd) - sext_w(p1_hold_reg));
        p2_val = is_last ? sat_w((sext_w(kb_reg) + sext_w(div_quo) + W_ONE) >>> 1)
                         : sat_w((sext_w(kb_reg) <<< 1) - sext_w(p1_hold_reg));

        lin_sum = sel_reg ? sext_w(ka_reg) + (sext_w(knot_cur) <<< 1)
                          : (sext_w(ka_reg) <<< 1) + sext_w(knot_cur);
        lin_mag = lin_sum[WIDE_W-1] ? WIDE_W'(-lin_sum) : WIDE_W'(lin_sum);

        // Rounded third: floor((|s| + 1) / 3) through the scaled reciprocal,
        // split into a high and a low partial product.
        lin_pl   = 50'(lin_x_reg[15:0]) * 50'(THIRD_RECIP);
        lin_full = {lin_ph_reg, 16'd0} + 67'(lin_pl);
        lin_q    = lin_full[66:35];
        lin_val  = lin_neg_reg ? 32'(33'd0 - {1'b0, lin_q}) : lin_q;

        state_next     = state_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        axis_next      = axis_reg;
        sel_next       = sel_reg;
        piv_prev_next  = piv_prev_reg;
        r_prev_next    = r_prev_reg;
        p1_hold_next   = p1_hold_reg;
        ka_next        = ka_reg;
        kb_next        = kb_reg;
        m_next         = m_reg;
        prod_next      = prod_reg;
        lin_x_next     = lin_x_reg;
        lin_neg_next   = lin_neg_reg;
        lin_ph_next    = lin_ph_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;

        job_pop    = 1'b0;
        div_req    = '0;
        knot_raddr = idx_reg;
        piv_we     = 1'b0;
        piv_wdata  = piv_val;
        m_we       = 1'b0;
        rhs_we     = 1'b0;
        rhs_wdata  = r_val;
        p1_we      = 3'b000;
        p2_we      = 3'b000;
        p1_wdata   = div_quo;
        p2_wdata   = p2_val;

        case (state_reg)
            BK_IDLE:
            begin
                if (job.valid)
                begin
                    job_pop    = 1'b1;
                    n_next     = KIDX_W'(job.cnt - CNT_W'(1));
                    idx_next   = '0;
                    axis_next  = 2'd0;
                    sel_next   = 1'b0;
                    state_next = (job.cnt == CNT_W'(2)) ? BK_LIN_RD0 : BK_PIV0;
                end
            end
            BK_PIV0:
            begin
                piv_we        = 1'b1;
                piv_wdata     = TWO_Q;
                piv_prev_next = TWO_Q;
                idx_next      = KIDX_W'(1);
                state_next    = BK_PIV_DIV;
            end
            BK_PIV_DIV:
            begin
                div_req    = qdiv_req(is_last ? TWO_Q : ONE_Q, piv_prev_reg);
                state_next = BK_PIV_WAIT;
            end
            BK_PIV_WAIT:
            begin
                if (div_done)
                begin
                    piv_we        = 1'b1;
                    m_we          = 1'b1;
                    piv_prev_next = piv_val;
                    if (is_last)
                    begin
                        idx_next   = '0;
                        axis_next  = 2'd0;
                        state_next = BK_RHS_RD0;
                    end
                    else
                    begin
                        idx_next   = idx_reg + KIDX_W'(1);
                        state_next = BK_PIV_DIV;
                    end
                end
            end
            BK_RHS_RD0:
            begin
                state_next = BK_RHS_RD1;
            end
            BK_RHS_RD1:
            begin
                ka_next    = knot_cur;
                m_next     = m_rd;
                knot_raddr = idx_reg + KIDX_W'(1);
                state_next = BK_RHS_MUL;
            end
            BK_RHS_MUL:
            begin
                kb_next    = knot_cur;
                prod_next  = m_reg * r_prev_reg;
                state_next = BK_RHS_WR;
            end
            BK_RHS_WR:
            begin
                rhs_we      = 1'b1;
                r_prev_next = r_val;
                if (is_last)
                begin
                    state_next = BK_BS_RD;
                end
                else
                begin
                    idx_next   = idx_reg + KIDX_W'(1);
                    state_next = BK_RHS_RD0;
                end
            end
            BK_BS_RD:
            begin
                knot_raddr = idx_reg + KIDX_W'(1);
                state_next = BK_BS_DIV;
            end
            BK_BS_DIV:
            begin
                knot_raddr = idx_reg + KIDX_W'(1);
                kb_next    = knot_cur;
                div_req    = qdiv_req(bs_num, piv_rd);
                state_next = BK_BS_WAIT;
            end
            BK_BS_WAIT:
            begin
                if (div_done)
                begin
                    p1_we[axis_reg] = 1'b1;
                    p2_we[axis_reg] = 1'b1;
                    p1_hold_next    = div_quo;
                    if (idx_reg == '0)
                    begin
                        if (axis_reg == 2'd2)
                        begin
                            state_next = BK_OUT_RD;
                        end
                        else
                        begin
                            axis_next  = axis_reg + 2'd1;
                            state_next = BK_RHS_RD0;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg - KIDX_W'(1);
                        state_next = BK_BS_RD;
                    end
                end
            end
            BK_OUT_RD:
            begin
                state_next = BK_OUT_EMIT;
            end
            BK_OUT_EMIT:
            begin
                res_valid_next         = 1'b1;
                res_next.segment       = SEG_W'(idx_reg);
                res_next.first_ctrl_x  = p1_rd[0];
                res_next.first_ctrl_y  = p1_rd[1];
                res_next.first_ctrl_z  = p1_rd[2];
                res_next.second_ctrl_x = p2_rd[0];
                res_next.second_ctrl_y = p2_rd[1];
                res_next.second_ctrl_z = p2_rd[2];
                res_next.final_segment = is_last;
                if (is_last)
                begin
                    state_next = BK_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + KIDX_W'(1);
                    state_next = BK_OUT_RD;
                end
            end
            BK_LIN_RD0:
            begin
                knot_raddr = '0;
                state_next = BK_LIN_RD1;
            end
            BK_LIN_RD1:
            begin
                ka_next    = knot_cur;
                knot_raddr = KIDX_W'(1);
                state_next = BK_LIN_ABS;
            end
            BK_LIN_ABS:
            begin
                lin_x_next   = 33'(lin_mag) + 33'd1;
                lin_neg_next = lin_sum[WIDE_W-1];
                state_next   = BK_LIN_MUL;
            end
            BK_LIN_MUL:
            begin
                lin_ph_next = 51'(lin_x_reg[32:16]) * 51'(THIRD_RECIP);
                state_next  = BK_LIN_SUM;
            end
            BK_LIN_SUM:
            begin
                p1_wdata = lin_val;
                p2_wdata = lin_val;
                if (sel_reg)
                begin
                    p2_we[axis_reg] = 1'b1;
                    sel_next        = 1'b0;
                    if (axis_reg == 2'd2)
                    begin
                        state_next = BK_OUT_RD;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = BK_LIN_RD0;
                    end
                end
                else
                begin
                    p1_we[axis_reg] = 1'b1;
                    sel_next        = 1'b1;
                    state_next      = BK_LIN_RD0;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            n_reg         <= '0;
            axis_reg      <= 2'd0;
            sel_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            axis_reg      <= axis_next;
            sel_reg       <= sel_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        piv_prev_reg <= piv_prev_next;
        r_prev_reg   <= r_prev_next;
        p1_hold_reg  <= p1_hold_next;
        ka_reg       <= ka_next;
        kb_reg       <= kb_next;
        m_reg        <= m_next;
        prod_reg     <= prod_next;
        lin_x_reg    <= lin_x_next;
        lin_neg_reg  <= lin_neg_next;
        lin_ph_reg   <= lin_ph_next;
        res_reg      <= res_next;
    end

    assign back_busy    = state_reg != BK_IDLE;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef SYNTH
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> $past(state_reg == BK_OUT_EMIT))
        else $error("result strobe without an emit step");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != BK_IDLE |-> idx_reg < n_reg)
        else $error("segment index out of range");
    a_div_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == BK_PIV_WAIT || state_reg == BK_BS_WAIT))
        else $error("divider result arrived while not awaited");
`endif

endmodule

[rtl/smooth_bezier_control_points.sv]
// ----------------------------------------------------------------------------
// Smooth Bezier control points
// Computes the inner control points of a smooth cubic Bezier spline through
// a set of 3-D knots given in signed fixed point.
// ----------------------------------------------------------------------------
// Knots enter on the command port: a knot is taken at a clock edge where
// start is high and busy is low, one knot per cycle while a set is loading
// and busy stays low. The knot with final_knot set closes the set. Knots
// past the store size are dropped, and a set of one knot gives no result.
// After the closing knot, busy stays high while the solver runs. Each
// result is shown for one cycle with result_valid high, in segment order,
// and final_segment marks the last one; the receiver takes every result.
// The solver is paced by its bit-serial divider, 48 steps per quotient;
// a two-knot set needs no division. Once streaming starts, each result
// of a run takes a read step and then an emit step.
// Reset clears the knot count and returns the solver to idle; no store
// needs clearing.
// ----------------------------------------------------------------------------
module smooth_bezier_control_points (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  sbcp_pkg::knot_t     knot,
    output logic                result_valid,
    output sbcp_pkg::result_t   result
);
    import sbcp_pkg::*;

    knot_wr_t          knot_wr;
    job_t              job;
    logic              job_pop;
    logic              back_busy;
    logic [KIDX_W-1:0] knot_raddr;
    logic [2:0][31:0]  knot_rd;
    logic [2:0][31:0]  knot_wdata;

    assign busy       = back_busy | job.valid;
    assign knot_wdata = {knot_wr.z, knot_wr.y, knot_wr.x};

    sbcp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .knot    (knot),
        .job_pop (job_pop),
        .knot_wr (knot_wr),
        .job     (job)
    );

    for (genvar a = 0; a < 3; a++)
    begin : g_knot
        sbcp_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_knot_ram (
            .clk   (clk),
            .we    (knot_wr.we),
            .waddr (knot_wr.addr),
            .wdata (knot_wdata[a]),
            .raddr (knot_raddr),
            .rdata (knot_rd[a])
        );
    end

    sbcp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (job),
        .job_pop      (job_pop),
        .knot_raddr   (knot_raddr),
        .knot_rd      (knot_rd),
        .back_busy    (back_busy),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
